@@ hdl/pdsc_pkg.sv @@
// ----------------------------------------------------------------------------
// pdsc_pkg
// Shared types and constants for the path dot-segment collapse unit.
// ----------------------------------------------------------------------------
package pdsc_pkg;

    // characters with a meaning in a path
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // kind of the component being built
    localparam logic [1:0] KIND_SLASH  = 2'd0;
    localparam logic [1:0] KIND_DOT    = 2'd1;
    localparam logic [1:0] KIND_DOTDOT = 2'd2;
    localparam logic [1:0] KIND_NAME   = 2'd3;

    // report status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_ABS = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    // opcode of an input item
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // field widths
    localparam int IDX_W = 12;
    localparam int LEN_W = 13;

    // entries of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // a classified item as it travels from front to back
    typedef struct packed {
        logic             is_read;
        logic             is_slash;
        logic             is_dot;
        logic             last;
        logic [7:0]       path_byte;
        logic [IDX_W-1:0] read_index;
    } t_item;

endpackage

@@ hdl/pdsc_front.sv @@
// ----------------------------------------------------------------------------
// pdsc_front
// Decodes an incoming item and marks slash and dot characters.
// ----------------------------------------------------------------------------
module pdsc_front (
    input  logic                     i_opcode,
    input  logic [7:0]               i_path_byte,
    input  logic                     i_end_of_path,
    input  logic [pdsc_pkg::IDX_W-1:0] i_read_index,
    output pdsc_pkg::t_item          o_item
);

    // character classes and opcode decode
    always_comb begin
        o_item.is_read    = (i_opcode == pdsc_pkg::OP_READ);
        o_item.is_slash   = (i_path_byte == pdsc_pkg::CH_SLASH);
        o_item.is_dot     = (i_path_byte == pdsc_pkg::CH_DOT);
        o_item.last       = i_end_of_path;
        o_item.path_byte  = i_path_byte;
        o_item.read_index = i_read_index;
    end

endmodule

@@ hdl/pdsc_fifo.sv @@
// ----------------------------------------------------------------------------
// pdsc_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module pdsc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_full,
    input  pdsc_pkg::t_item i_item,
    output logic            o_head_valid,
    output pdsc_pkg::t_item o_head,
    input  logic            i_pop
);

    localparam int QAW = $clog2(pdsc_pkg::QUEUE_DEPTH);
    localparam int CW  = QAW + 1;

    pdsc_pkg::t_item r_mem [pdsc_pkg::QUEUE_DEPTH];
    logic [QAW-1:0]  r_wr;
    logic [QAW-1:0]  r_rd;
    logic [CW-1:0]   r_cnt;
    logic            push;

    assign o_full       = (r_cnt == CW'(pdsc_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];
    assign push         = i_push_valid && !o_full;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

@@ hdl/pdsc_back.sv @@
// ----------------------------------------------------------------------------
// pdsc_back
// Executes queued items: builds the normalized path, answers reads, reports.
// ----------------------------------------------------------------------------
module pdsc_back #(
    parameter int PATH_BUF = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_head_valid,
    input  pdsc_pkg::t_item            i_head,
    output logic                       o_head_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_is_read_reply,
    output logic [1:0]                 o_status,
    output logic [pdsc_pkg::LEN_W-1:0] o_result_length,
    output logic [7:0]                 o_result_byte
);

    localparam int AW    = $clog2(PATH_BUF);
    localparam int PW    = AW + 1;
    localparam int SLOTS = PATH_BUF / 2 + 1;
    localparam int SAW   = $clog2(SLOTS);
    localparam int DW    = $clog2(SLOTS + 1);
    localparam logic [PW-1:0] LIMIT = PW'(PATH_BUF - 3);

    localparam logic [1:0] S_RUN   = 2'd0;
    localparam logic [1:0] S_POP   = 2'd1;
    localparam logic [1:0] S_RDATA = 2'd2;

    // path state
    logic [1:0]    r_state, n_state;
    logic          r_start, n_start;
    logic [1:0]    r_err, n_err;
    logic [1:0]    r_kind, n_kind;
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_cons, n_cons;
    logic [DW-1:0] r_depth, n_depth;
    logic [AW-1:0] r_top, n_top;
    logic          r_pop_slash, n_pop_slash;
    logic          r_pop_last, n_pop_last;
    logic [1:0]    r_rd_status, n_rd_status;
    logic [PW-1:0] r_rd_len, n_rd_len;
    logic          r_rd_hit, n_rd_hit;

    // memories and their read data
    logic [7:0]    r_store [PATH_BUF];
    logic [AW-1:0] r_stack [SLOTS];
    logic [7:0]    r_st_q;
    logic [AW-1:0] r_sk_q;

    // output register
    logic                       r_ov;
    logic                       r_o_read;
    logic [1:0]                 r_o_status;
    logic [pdsc_pkg::LEN_W-1:0] r_o_len;
    logic [7:0]                 r_o_byte;

    // memory port controls
    logic           st_we, st_re;
    logic [AW-1:0]  st_wa, st_ra;
    logic [7:0]     st_wd;
    logic           sk_we, sk_re;
    logic [SAW-1:0] sk_wa, sk_ra;
    logic [AW-1:0]  sk_wd;

    // output load controls
    logic          out_free;
    logic          load_out;
    logic          ld_read;
    logic [1:0]    ld_status;
    logic [PW-1:0] ld_len;
    logic [7:0]    ld_byte;
    logic          go_pop;
    logic [PW-1:0] fin_wp;
    logic [31:0]   idx_ext;

    assign out_free = !r_ov || !i_out_stall;
    assign idx_ext  = 32'(i_head.read_index);

    // item execution
    always_comb begin
        n_state     = r_state;
        n_start     = r_start;
        n_err       = r_err;
        n_kind      = r_kind;
        n_wp        = r_wp;
        n_cons      = r_cons;
        n_depth     = r_depth;
        n_top       = r_top;
        n_pop_slash = r_pop_slash;
        n_pop_last  = r_pop_last;
        n_rd_status = r_rd_status;
        n_rd_len    = r_rd_len;
        n_rd_hit    = r_rd_hit;
        st_we       = 1'b0;
        st_wa       = '0;
        st_wd       = '0;
        st_re       = 1'b0;
        st_ra       = '0;
        sk_we       = 1'b0;
        sk_wa       = '0;
        sk_wd       = '0;
        sk_re       = 1'b0;
        sk_ra       = '0;
        o_head_pop  = 1'b0;
        load_out    = 1'b0;
        ld_read     = 1'b0;
        ld_status   = '0;
        ld_len      = '0;
        ld_byte     = '0;
        go_pop      = 1'b0;
        fin_wp      = '0;

        unique case (r_state)
            S_RUN: begin
                if (i_head_valid && i_head.is_read) begin
                    // read: issue store read, capture status and length now
                    if (out_free) begin
                        o_head_pop  = 1'b1;
                        st_re       = 1'b1;
                        st_ra       = idx_ext[AW-1:0];
                        n_rd_status = r_err;
                        n_rd_len    = r_wp;
                        n_rd_hit    = (idx_ext < 32'(r_wp)) && (idx_ext < 32'(PATH_BUF));
                        n_state     = S_RDATA;
                    end
                end else if (i_head_valid && (!i_head.last || out_free)) begin
                    o_head_pop = 1'b1;
                    if (r_start) begin
                        // first byte of a path
                        n_start = 1'b0;
                        n_wp    = '0;
                        n_depth = '0;
                        n_kind  = pdsc_pkg::KIND_SLASH;
                        n_cons  = PW'(1);
                        n_err   = pdsc_pkg::ST_OK;
                        if (!i_head.is_slash) begin
                            n_err = pdsc_pkg::ST_NOT_ABS;
                        end else begin
                            sk_we   = 1'b1;
                            sk_wa   = '0;
                            sk_wd   = '0;
                            n_top   = '0;
                            n_depth = DW'(1);
                            st_we   = 1'b1;
                            st_wa   = '0;
                            st_wd   = pdsc_pkg::CH_SLASH;
                            n_wp    = PW'(1);
                        end
                    end else if (r_err != pdsc_pkg::ST_OK) begin
                        n_err = r_err;
                    end else if (r_cons >= LIMIT) begin
                        n_err = pdsc_pkg::ST_TOO_LONG;
                    end else begin
                        n_cons = r_cons + PW'(1);
                        if (i_head.is_slash) begin
                            // slash closes the current component
                            unique case (r_kind)
                                pdsc_pkg::KIND_NAME: begin
                                    if (r_depth < DW'(SLOTS)) begin
                                        sk_we   = 1'b1;
                                        sk_wa   = r_depth[SAW-1:0];
                                        sk_wd   = r_wp[AW-1:0];
                                        n_top   = r_wp[AW-1:0];
                                        n_depth = r_depth + DW'(1);
                                    end
                                    if (r_wp < PW'(PATH_BUF)) begin
                                        st_we = 1'b1;
                                        st_wa = r_wp[AW-1:0];
                                        st_wd = pdsc_pkg::CH_SLASH;
                                        n_wp  = r_wp + PW'(1);
                                    end
                                end
                                pdsc_pkg::KIND_DOT: begin
                                    n_wp = {1'b0, r_top} + PW'(1);
                                end
                                pdsc_pkg::KIND_DOTDOT: begin
                                    if (r_depth >= DW'(2)) begin
                                        n_depth     = r_depth - DW'(1);
                                        sk_re       = 1'b1;
                                        sk_ra       = SAW'(r_depth - DW'(2));
                                        go_pop      = 1'b1;
                                        n_pop_slash = 1'b1;
                                        n_pop_last  = i_head.last;
                                    end else begin
                                        n_wp = {1'b0, r_top} + PW'(1);
                                    end
                                end
                                default: begin
                                    n_wp = r_wp;
                                end
                            endcase
                            n_kind = pdsc_pkg::KIND_SLASH;
                        end else begin
                            // name character
                            if (i_head.is_dot && r_kind == pdsc_pkg::KIND_SLASH) begin
                                n_kind = pdsc_pkg::KIND_DOT;
                            end else if (i_head.is_dot && r_kind == pdsc_pkg::KIND_DOT) begin
                                n_kind = pdsc_pkg::KIND_DOTDOT;
                            end else begin
                                n_kind = pdsc_pkg::KIND_NAME;
                            end
                            if (r_wp < PW'(PATH_BUF)) begin
                                st_we = 1'b1;
                                st_wa = r_wp[AW-1:0];
                                st_wd = i_head.path_byte;
                                n_wp  = r_wp + PW'(1);
                            end
                        end
                    end

                    // end of path: trailing dot segments and report
                    if (i_head.last && !go_pop) begin
                        fin_wp = n_wp;
                        if (n_err != pdsc_pkg::ST_OK) begin
                            fin_wp = '0;
                        end else if (n_kind == pdsc_pkg::KIND_DOT) begin
                            fin_wp = {1'b0, n_top};
                        end else if (n_kind == pdsc_pkg::KIND_DOTDOT) begin
                            if (n_depth >= DW'(2)) begin
                                sk_re       = 1'b1;
                                sk_ra       = SAW'(n_depth - DW'(2));
                                n_depth     = n_depth - DW'(1);
                                go_pop      = 1'b1;
                                n_pop_slash = 1'b0;
                                n_pop_last  = 1'b1;
                            end else begin
                                fin_wp = '0;
                            end
                        end
                        if (!go_pop) begin
                            if (n_err == pdsc_pkg::ST_OK && fin_wp == '0) begin
                                st_we  = 1'b1;
                                st_wa  = '0;
                                st_wd  = pdsc_pkg::CH_SLASH;
                                fin_wp = PW'(1);
                            end
                            n_wp      = fin_wp;
                            n_start   = 1'b1;
                            n_kind    = pdsc_pkg::KIND_SLASH;
                            n_depth   = '0;
                            n_cons    = '0;
                            load_out  = 1'b1;
                            ld_status = n_err;
                            ld_len    = fin_wp;
                        end
                    end
                    if (go_pop) begin
                        n_state = S_POP;
                    end
                end
            end
            S_POP: begin
                // new top of the stack has arrived
                n_top  = r_sk_q;
                fin_wp = r_pop_slash ? ({1'b0, r_sk_q} + PW'(1)) : {1'b0, r_sk_q};
                if (r_pop_last) begin
                    if (fin_wp == '0) begin
                        st_we  = 1'b1;
                        st_wa  = '0;
                        st_wd  = pdsc_pkg::CH_SLASH;
                        fin_wp = PW'(1);
                    end
                    n_start   = 1'b1;
                    n_kind    = pdsc_pkg::KIND_SLASH;
                    n_depth   = '0;
                    n_cons    = '0;
                    load_out  = 1'b1;
                    ld_status = r_err;
                    ld_len    = fin_wp;
                end
                n_wp    = fin_wp;
                n_state = S_RUN;
            end
            S_RDATA: begin
                // store data has arrived for a read
                load_out  = 1'b1;
                ld_read   = 1'b1;
                ld_status = r_rd_status;
                ld_len    = r_rd_len;
                ld_byte   = r_rd_hit ? r_st_q : 8'd0;
                n_state   = S_RUN;
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_start <= 1'b1;
            r_err   <= pdsc_pkg::ST_OK;
            r_kind  <= pdsc_pkg::KIND_SLASH;
            r_wp    <= '0;
            r_cons  <= '0;
            r_depth <= '0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
            r_err   <= n_err;
            r_kind  <= n_kind;
            r_wp    <= n_wp;
            r_cons  <= n_cons;
            r_depth <= n_depth;
        end
    end

    // side registers of the path state
    always_ff @(posedge i_clk) begin
        r_top       <= n_top;
        r_pop_slash <= n_pop_slash;
        r_pop_last  <= n_pop_last;
        r_rd_status <= n_rd_status;
        r_rd_len    <= n_rd_len;
        r_rd_hit    <= n_rd_hit;
    end

    // path store
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_wa] <= st_wd;
        end
        if (st_re) begin
            r_st_q <= r_store[st_ra];
        end
    end

    // slash position stack
    always_ff @(posedge i_clk) begin
        if (sk_we) begin
            r_stack[sk_wa] <= sk_wd;
        end
        if (sk_re) begin
            r_sk_q <= r_stack[sk_ra];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load_out) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_read   <= ld_read;
            r_o_status <= ld_status;
            r_o_len    <= pdsc_pkg::LEN_W'(ld_len);
            r_o_byte   <= ld_byte;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_is_read_reply = r_o_read;
    assign o_status        = r_o_status;
    assign o_result_length = r_o_len;
    assign o_result_byte   = r_o_byte;

    // a stack refill only ever follows an item taken in the run state
    a_pop_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> ($past(r_state) == S_RUN))
        else $error("stack refill without a preceding item");

    // store data wait always ends in a read reply
    a_rdata_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDATA) |=> (r_ov && o_is_read_reply))
        else $error("read reply missing after store read");

    // a path in progress without error keeps at least the root slash
    a_root_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_start && r_err == pdsc_pkg::ST_OK && r_state == S_RUN) |-> (r_depth != '0))
        else $error("slash stack empty inside a valid path");

    // a pending result is never overwritten while stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_out_stall) |-> !load_out)
        else $error("result loaded over a stalled result");

endmodule

@@ hdl/path_dot_segment_collapse_unit.sv @@
// ----------------------------------------------------------------------------
// path_dot_segment_collapse_unit
// Normalizes an absolute path fed one byte per transfer and serves reads
// of the normalized result.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   opcode, path_byte, end_of_path,
//                                                 read_index
//  out       output     o_out_valid / i_out_stall is_read_reply, status,
//                                                 result_length, result_byte
//
// Most appends finish in the run state. A ".." component that pops a kept
// component, closed by a slash or by the end of the path, also goes via
// the pop state: the new stack top comes from the slash stack memory,
// whose read is registered. A read waits for the registered store read.
// Reset is synchronous and active low; the stores need no clearing pass.
// A four-entry queue separates input acceptance from execution, and a
// result register lets the next transfer enter while a result is stalled.
// ----------------------------------------------------------------------------
module path_dot_segment_collapse_unit #(
    parameter int PATH_BUF = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_path_byte,
    input  logic        i_end_of_path,
    input  logic [11:0] i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_is_read_reply,
    output logic [1:0]  o_status,
    output logic [12:0] o_result_length,
    output logic [7:0]  o_result_byte
);

    pdsc_pkg::t_item in_item;
    pdsc_pkg::t_item head_item;
    logic            head_valid;
    logic            head_pop;

    // classify incoming transfers
    pdsc_front u_front (
        .i_opcode      (i_opcode),
        .i_path_byte   (i_path_byte),
        .i_end_of_path (i_end_of_path),
        .i_read_index  (i_read_index),
        .o_item        (in_item)
    );

    // queue between front and back
    pdsc_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_in_valid),
        .o_full       (o_in_stall),
        .i_item       (in_item),
        .o_head_valid (head_valid),
        .o_head       (head_item),
        .i_pop        (head_pop)
    );

    // execution and result register
    pdsc_back #(
        .PATH_BUF (PATH_BUF)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (head_valid),
        .i_head          (head_item),
        .o_head_pop      (head_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_is_read_reply (o_is_read_reply),
        .o_status        (o_status),
        .o_result_length (o_result_length),
        .o_result_byte   (o_result_byte)
    );

endmodule

@@ tb/sv/path_norm_tracker_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// path_norm_tracker_pkg
// Predicts the reports and read replies of the path dot-segment collapse
// unit and checks the results that leave the block against them.
// ----------------------------------------------------------------------------
package path_norm_tracker_pkg;

    localparam int PATH_BUF    = 4096;
    localparam int SLASH_SLOTS = PATH_BUF / 2 + 1;

    // one result as the block should deliver it
    typedef struct {
        logic        is_read;
        logic [1:0]  status;
        logic [12:0] length;
        logic [7:0]  rbyte;
    } t_reply;

    class path_norm_tracker;

        // normalized path built so far and the slashes that lead kept components
        bit [7:0]    store [PATH_BUF];
        int unsigned slash_pos [SLASH_SLOTS];
        int unsigned depth;
        int unsigned wp;
        int unsigned consumed;
        logic [1:0]  kind;
        logic [1:0]  err;
        bit          at_start;

        // results owed by the block, oldest first
        t_reply      owed [$];
        int          fail_count;

        function new();
            depth      = 0;
            wp         = 0;
            consumed   = 0;
            kind       = pdsc_pkg::KIND_SLASH;
            err        = pdsc_pkg::ST_OK;
            at_start   = 1'b1;
            fail_count = 0;
        endfunction

        function int unsigned top_slash();
            if (depth == 0)
                return 0;
            return slash_pos[depth-1];
        endfunction

        // note one accepted input transfer and work out what it owes
        function void take_input(logic op, logic [7:0] b, logic last, logic [11:0] idx);
            t_reply r;
            if (op == pdsc_pkg::OP_READ) begin
                r.is_read = 1'b1;
                r.status  = err;
                r.length  = 13'(wp);
                r.rbyte   = (idx < wp) ? store[idx] : 8'd0;
                owed.push_back(r);
                return;
            end

            // absorb one path byte
            if (at_start) begin
                at_start = 1'b0;
                wp       = 0;
                depth    = 0;
                kind     = pdsc_pkg::KIND_SLASH;
                consumed = 1;
                err      = pdsc_pkg::ST_OK;
                if (b != pdsc_pkg::CH_SLASH) begin
                    err = pdsc_pkg::ST_NOT_ABS;
                end else begin
                    slash_pos[0] = 0;
                    depth        = 1;
                    store[0]     = b;
                    wp           = 1;
                end
            end else if (err == pdsc_pkg::ST_OK) begin
                if (consumed >= PATH_BUF - 3) begin
                    err = pdsc_pkg::ST_TOO_LONG;
                end else begin
                    consumed++;
                    if (b == pdsc_pkg::CH_SLASH) begin
                        // a slash closes the current component
                        case (kind)
                            pdsc_pkg::KIND_NAME: begin
                                if (depth < SLASH_SLOTS) begin
                                    slash_pos[depth] = wp;
                                    depth++;
                                end
                                if (wp < PATH_BUF) begin
                                    store[wp] = pdsc_pkg::CH_SLASH;
                                    wp++;
                                end
                            end
                            pdsc_pkg::KIND_DOT: begin
                                wp = top_slash() + 1;
                            end
                            pdsc_pkg::KIND_DOTDOT: begin
                                if (depth >= 2)
                                    depth--;
                                wp = top_slash() + 1;
                            end
                            default: begin
                            end
                        endcase
                        kind = pdsc_pkg::KIND_SLASH;
                    end else begin
                        if (b == pdsc_pkg::CH_DOT && kind == pdsc_pkg::KIND_SLASH)
                            kind = pdsc_pkg::KIND_DOT;
                        else if (b == pdsc_pkg::CH_DOT && kind == pdsc_pkg::KIND_DOT)
                            kind = pdsc_pkg::KIND_DOTDOT;
                        else
                            kind = pdsc_pkg::KIND_NAME;
                        if (wp < PATH_BUF) begin
                            store[wp] = b;
                            wp++;
                        end
                    end
                end
            end

            if (!last)
                return;

            // close the path: trailing dot segments drop their slash
            if (err != pdsc_pkg::ST_OK) begin
                wp = 0;
            end else begin
                if (kind == pdsc_pkg::KIND_DOT) begin
                    wp = top_slash();
                end else if (kind == pdsc_pkg::KIND_DOTDOT) begin
                    if (depth >= 2) begin
                        depth--;
                        wp = top_slash();
                    end else begin
                        wp = 0;
                    end
                end
                if (wp == 0) begin
                    store[0] = pdsc_pkg::CH_SLASH;
                    wp       = 1;
                end
            end
            at_start = 1'b1;
            kind     = pdsc_pkg::KIND_SLASH;
            depth    = 0;
            consumed = 0;

            r.is_read = 1'b0;
            r.status  = err;
            r.length  = 13'(wp);
            r.rbyte   = 8'd0;
            owed.push_back(r);
        endfunction

        function void compare_field(string name, logic [12:0] want, logic [12:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                fail_count++;
            end
        endfunction

        // check one result transfer against the oldest owed result
        function void check_result(logic is_read, logic [1:0] status, logic [12:0] length,
                                   logic [7:0] rbyte);
            t_reply e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result, expected none, %s %0b %0d %0d %0d",
                         $time, "actual read status length byte",
                         is_read, status, length, rbyte);
                fail_count++;
                return;
            end
            e = owed.pop_front();
            compare_field("is_read_reply", 13'(e.is_read), 13'(is_read));
            compare_field("status", 13'(e.status), 13'(status));
            compare_field("result_length", e.length, length);
            compare_field("result_byte", 13'(e.rbyte), 13'(rbyte));
        endfunction

    endclass

endpackage

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds the path dot-segment collapse unit with directed paths and random
// well-formed and broken paths mixed with reads, under several idle and
// stall patterns and one long receiver hold-off.
// Every result transfer is checked against the tracker's prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 135;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_opcode = pdsc_pkg::OP_APPEND;
    logic [7:0]  i_path_byte = 8'd0;
    logic        i_end_of_path = 1'b0;
    logic [11:0] i_read_index = 12'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_is_read_reply;
    logic [1:0]  o_status;
    logic [12:0] o_result_length;
    logic [7:0]  o_result_byte;

    path_norm_tracker_pkg::path_norm_tracker tracker;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int items_sent = 0;
    int cycle_count = 0;

    path_dot_segment_collapse_unit #(
        .PATH_BUF(path_norm_tracker_pkg::PATH_BUF)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_path_byte    (i_path_byte),
        .i_end_of_path  (i_end_of_path),
        .i_read_index   (i_read_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_is_read_reply(o_is_read_reply),
        .o_status       (o_status),
        .o_result_length(o_result_length),
        .o_result_byte  (o_result_byte)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: check result transfers, stall at random or hold off on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_result(o_is_read_reply, o_status, o_result_length, o_result_byte);
        if (hold_left == 0 && hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // offer one input transfer and wait until it is taken
    task automatic send_item(input logic op, input logic [7:0] b, input logic last,
                             input logic [11:0] idx);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_path_byte   <= b;
        i_end_of_path <= last;
        i_read_index  <= idx;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        tracker.take_input(op, b, last, idx);
        items_sent++;
    endtask

    // read one result byte, mostly near the built path
    task automatic send_read();
        int unsigned idx;
        if ($urandom_range(9) < 7)
            idx = $urandom_range(tracker.wp + 1, 0);
        else
            idx = $urandom_range(4095);
        if (idx > 4095)
            idx = 4095;
        send_item(pdsc_pkg::OP_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  12'(idx));
    endtask

    // send a whole path, reads slipped in between its bytes
    task automatic send_path(input logic [7:0] bytes [$], input int read_pct);
        for (int i = 0; i < bytes.size(); i++) begin
            if ($urandom_range(99) < read_pct)
                send_read();
            send_item(pdsc_pkg::OP_APPEND, bytes[i], i == bytes.size() - 1,
                      12'($urandom_range(4095)));
        end
    endtask

    task automatic send_text(input string s);
        logic [7:0] q [$];
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        send_path(q, 0);
    endtask

    // random path built from components, sometimes not absolute
    task automatic send_random_path();
        logic [7:0] q [$];
        logic [7:0] b;
        int ntok;
        if ($urandom_range(9) == 0) begin
            do
                b = 8'($urandom_range(255));
            while (b == pdsc_pkg::CH_SLASH);
            q.push_back(b);
        end else begin
            q.push_back(pdsc_pkg::CH_SLASH);
        end
        ntok = $urandom_range(6, 1);
        for (int t = 0; t < ntok; t++) begin
            case ($urandom_range(7))
                0: q.push_back(pdsc_pkg::CH_SLASH);
                1: begin
                    q.push_back(pdsc_pkg::CH_SLASH);
                    q.push_back(pdsc_pkg::CH_SLASH);
                end
                2: q.push_back(pdsc_pkg::CH_DOT);
                3: begin
                    q.push_back(pdsc_pkg::CH_DOT);
                    q.push_back(pdsc_pkg::CH_DOT);
                end
                4: repeat (3) q.push_back(pdsc_pkg::CH_DOT);
                5: begin
                    q.push_back(pdsc_pkg::CH_DOT);
                    q.push_back(8'($urandom_range(255)));
                end
                6: repeat ($urandom_range(4, 1)) q.push_back(8'($urandom_range(255)));
                default: repeat ($urandom_range(3, 1)) q.push_back(8'h61 + 8'($urandom_range(25)));
            endcase
            if ($urandom_range(9) < 7)
                q.push_back(pdsc_pkg::CH_SLASH);
        end
        send_path(q, 15);
    endtask

    initial begin
        int tx_pct [4] = '{0, 60, 0, 33};
        int rx_pct [4] = '{0, 0, 60, 33};
        int start;
        logic [7:0] odd_bytes [$];

        tracker = new();

        // reset
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed paths: slashes, dot segments, root, odd bytes, not absolute
        send_text("a/");
        send_text("//x/./");
        send_text("/x/..");
        send_text("/../.x");
        odd_bytes = '{pdsc_pkg::CH_SLASH, 8'h00, 8'hFF, pdsc_pkg::CH_SLASH, pdsc_pkg::CH_DOT};
        send_path(odd_bytes, 0);
        send_item(pdsc_pkg::OP_READ, 8'h00, 1'b0, 12'd0);
        send_item(pdsc_pkg::OP_READ, 8'hFF, 1'b1, 12'd2);
        send_item(pdsc_pkg::OP_READ, 8'h00, 1'b0, 12'd4095);

        // random paths under each idle pattern
        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = tx_pct[ph];
            rx_stall_pct = rx_pct[ph];
            start = items_sent;
            while (items_sent < start + PHASE_ITEMS)
                send_random_path();
        end

        // receiver holds off while the sender keeps offering
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = 400;
        repeat (40) send_read();
        send_random_path();

        // drain
        i_in_valid <= 1'b0;
        while (tracker.owed.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.fail_count == 0 && tracker.owed.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
